// ----- rtl/ple_pkg.sv -----
// Shared types, codes and constants for the positional list engine.
package ple_pkg;

    localparam int unsigned CAPACITY_DEFAULT = 16;
    localparam int unsigned VALUE_W          = 32;
    localparam int unsigned POS_W            = 8;
    localparam int unsigned REQ_W            = 3;
    localparam int unsigned STATUS_W         = 2;
    localparam int unsigned ITEM_INDEX_W     = 4;
    localparam int unsigned LENGTH_W         = 5;
    localparam int unsigned CMP_W            = POS_W + 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT     = 3'd0,
        REQ_DELETE_POS = 3'd1,
        REQ_DELETE_END = 3'd2,
        REQ_UPDATE_POS = 3'd3,
        REQ_UPDATE_END = 3'd4,
        REQ_READ_ALL   = 3'd5
    } req_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_WRITE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic [POS_W-1:0]           pos;
        logic signed [VALUE_W-1:0]  value;
    } cell_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0]           req_type;
        logic [POS_W-1:0]           position;
        logic signed [VALUE_W-1:0]  value;
    } req_payload_t;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [VALUE_W-1:0]  item_value;
        logic [ITEM_INDEX_W-1:0]    item_index;
        logic [LENGTH_W-1:0]        list_length;
        logic                       last;
    } rsp_payload_t;

endpackage

// ----- rtl/ple_stream_if.sv -----
// Valid/ready stream channel carrying one payload per beat.
interface ple_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/ple_cell.sv -----
// One list cell: holds a value and takes a neighbour's value on shift.
module ple_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                                clk,
    input  ple_pkg::cell_cmd_t                  cmd,
    input  logic signed [ple_pkg::VALUE_W-1:0]  left_value,
    input  logic signed [ple_pkg::VALUE_W-1:0]  right_value,
    output logic signed [ple_pkg::VALUE_W-1:0]  value
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] MY_INDEX = POS_W'(INDEX);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
                value_next = value_reg;
            end
            CELL_INSERT:
            begin
                if (MY_INDEX == cmd.pos)
                begin
                    value_next = cmd.value;
                end
                else if (MY_INDEX > cmd.pos)
                begin
                    value_next = left_value;
                end
            end
            CELL_DELETE:
            begin
                if (MY_INDEX >= cmd.pos)
                begin
                    value_next = right_value;
                end
            end
            CELL_WRITE:
            begin
                if (MY_INDEX == cmd.pos)
                begin
                    value_next = cmd.value;
                end
            end
            CELL_ROTATE:
            begin
                // pos marks the tail; the head wraps round into it
                if (MY_INDEX == cmd.pos)
                begin
                    value_next = cmd.value;
                end
                else if (MY_INDEX < cmd.pos)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- rtl/positional_list_engine.sv -----
// Top level of the positional list engine: control, count and the cell row.
//
// A bounded ordered list of signed 32-bit values held in a row of CAPACITY
// cells plus an element count. Insert, delete, update and the unused request
// codes each give one result beat: every cell decides its next value from
// its neighbours in parallel, so a new request is taken every cycle while the
// output register is free or being drained. Read-all gives one beat per
// element (a single beat for an empty list): the cell row rotates one place
// towards the head for each beat, the head cell feeding the output register,
// and after the last element the row is back in its original order. Requests
// are held off during a read-out and whenever the output register is stalled.
module positional_list_engine #(
    parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    ple_stream_if.sink   req,
    ple_stream_if.source rsp
);
    import ple_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = $clog2(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [IDX_W-1:0]    rd_idx_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_payload_t        rsp_data_reg;
    rsp_payload_t        rsp_data_next;
    logic                load;

    logic                out_free;
    logic                accept;
    req_payload_t        rq;
    logic [CMP_W-1:0]    pos_cmp;
    logic [CMP_W-1:0]    cnt_cmp;
    logic                is_empty;
    logic                is_full;
    logic [CNT_W-1:0]    count_last;
    logic                read_last;
    cell_cmd_t           cmd;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];

    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign req.ready  = (state_reg == S_IDLE) && out_free;
    assign accept     = req.valid && req.ready;
    assign rq         = req.payload;
    assign pos_cmp    = CMP_W'(rq.position);
    assign cnt_cmp    = CMP_W'(count_reg);
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == CNT_W'(CAPACITY));
    assign count_last = count_reg - CNT_W'(1);
    assign read_last  = (rd_idx_reg == IDX_W'(count_last));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        load           = 1'b0;
        rsp_data_next  = '{status: ST_OK, item_value: '0, item_index: '0,
                          list_length: '0, last: 1'b1};
        cmd            = '{op: CELL_HOLD, pos: '0, value: '0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    case (rq.req_type)
                        REQ_INSERT:
                        begin
                            if (is_full)
                            begin
                                rsp_data_next.status = ST_FULL;
                            end
                            else if (pos_cmp > cnt_cmp)
                            begin
                                rsp_data_next.status = ST_RANGE;
                            end
                            else
                            begin
                                cmd        = '{op: CELL_INSERT, pos: rq.position,
                                               value: rq.value};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_DELETE_POS:
                        begin
                            if (is_empty)
                            begin
                                rsp_data_next.status = ST_EMPTY;
                            end
                            else if (pos_cmp >= cnt_cmp)
                            begin
                                rsp_data_next.status = ST_RANGE;
                            end
                            else
                            begin
                                cmd        = '{op: CELL_DELETE, pos: rq.position,
                                               value: '0};
                                count_next = count_last;
                            end
                        end
                        REQ_DELETE_END:
                        begin
                            if (is_empty)
                            begin
                                rsp_data_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_last;
                            end
                        end
                        REQ_UPDATE_POS:
                        begin
                            if (is_empty)
                            begin
                                rsp_data_next.status = ST_EMPTY;
                            end
                            else if (pos_cmp >= cnt_cmp)
                            begin
                                rsp_data_next.status = ST_RANGE;
                            end
                            else
                            begin
                                cmd = '{op: CELL_WRITE, pos: rq.position,
                                        value: rq.value};
                            end
                        end
                        REQ_UPDATE_END:
                        begin
                            if (is_empty)
                            begin
                                rsp_data_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd = '{op: CELL_WRITE, pos: POS_W'(count_last),
                                        value: rq.value};
                            end
                        end
                        REQ_READ_ALL:
                        begin
                            if (!is_empty)
                            begin
                                load        = 1'b0;
                                state_next  = S_READ;
                                rd_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            rsp_data_next.status = ST_OK;
                        end
                    endcase
                    rsp_data_next.list_length = LENGTH_W'(count_next);
                    rsp_valid_next            = load || rsp_valid_next;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    cmd  = '{op: CELL_ROTATE, pos: POS_W'(count_last),
                             value: cell_value[0]};
                    rsp_data_next = '{status: ST_OK, item_value: cell_value[0],
                                      item_index: ITEM_INDEX_W'(rd_idx_reg),
                                      list_length: LENGTH_W'(count_reg),
                                      last: read_last};
                    rsp_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg + IDX_W'(1);
                    if (read_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_value;
        logic signed [VALUE_W-1:0] right_value;

        if (i == 0)
        begin : g_head
            assign left_value = '0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value = '0;
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        ple_cell #(
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i])
        );
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_read_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> CNT_W'(rd_idx_reg) < count_reg)
        else $error("read-out index past list length");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count changed without a request");

    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.payload.last |-> state_reg == S_READ)
        else $error("non-final beat outside read-out");

endmodule
